>>> hdl/ngga_pkg.sv
package ngga_pkg;

  // default build values
  localparam int FRAC_DIGITS_DEF = 4;
  localparam int FIELD_CHARS_DEF = 9;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int OFFSET_W  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_ONE = 1'b0,
    CFG_ZONE_TWO = 1'b1
  } cfg_idx_t;

  localparam logic [OFFSET_W-1:0] ZONE_ONE_RST = 5'd1;
  localparam logic [OFFSET_W-1:0] ZONE_TWO_RST = 5'd17;

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // field numbers and counter limits
  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_SAT  = 4'd7;
  localparam logic [3:0] CNT_MAX  = 4'd15;
  localparam int         TIME_CHARS = 6;

  // field widths
  localparam int HOUR_W = 7;
  localparam int ZONE_W = 5;
  localparam int SAT_W  = 7;
  localparam int DEG_W  = 31;

  localparam logic [SAT_W-1:0] SAT_MAX = 7'd99;

  // ddmm integer part, saturates at 180 degrees
  localparam int                 IPART_W   = 15;
  localparam logic [IPART_W-1:0] IPART_MAX = 15'd18000;

  localparam logic [DEG_W-1:0] DEG_LIMIT = 31'd1800000000;
  localparam int               DEG_UNIT  = 10000000;

  // powers of ten for fraction digit weights
  localparam logic [23:0] POW10 [0:7] = '{
    24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000, 24'd10000000
  };

  // fields that ride alongside the coordinate conversion
  typedef struct packed {
    logic              ok;
    logic [HOUR_W-1:0] hour;
    logic [ZONE_W-1:0] zone_one;
    logic [ZONE_W-1:0] zone_two;
    logic [HOUR_W-1:0] minute;
    logic [HOUR_W-1:0] second;
    logic [SAT_W-1:0]  sat;
  } side_t;

  // load strobes for the conversion stages
  typedef struct packed {
    logic deg;
    logic mins;
    logic prod;
    logic quot;
    logic sum;
  } conv_ld_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic int frac_width(input int n);
    return $clog2(pow10(n));
  endfunction

  // (s mod 24) for s below 192
  function automatic logic [ZONE_W-1:0] mod24(input logic [7:0] s);
    logic [7:0] t;
    t = s;
    if (t >= 8'd96) t = t - 8'd96;
    if (t >= 8'd48) t = t - 8'd48;
    if (t >= 8'd24) t = t - 8'd24;
    return t[ZONE_W-1:0];
  endfunction

  function automatic logic [HOUR_W-1:0] two_digit(input logic [3:0] hi, input logic [3:0] lo);
    return HOUR_W'(hi) * 7'd10 + HOUR_W'(lo);
  endfunction

endpackage

>>> hdl/nmea_gga_sentence_parser.sv
// GGA sentence parser: one character word accepted per cycle, at full rate unless
// out_ready back-pressure fills the pipeline. A result passes the capture stage,
// the 5-stage degree conversion and the output register. Up to 7 sentence results
// may be in flight, so one result per cycle is sustained while out_ready is high.
// Reset (rst_n low, synchronous) clears the parse state, pipeline valid flags and
// held results to zero, arms sentence start, loads zone offsets with 1 and 17.
module nmea_gga_sentence_parser #(
  parameter int FRAC_DIGITS = ngga_pkg::FRAC_DIGITS_DEF,
  parameter int FIELD_CHARS = ngga_pkg::FIELD_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // character input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_char_byte,
  input  logic                              in_last_char,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_sentence_ok,
  output logic [ngga_pkg::HOUR_W-1:0]       out_utc_hour,
  output logic [ngga_pkg::ZONE_W-1:0]       out_zone_one_hour,
  output logic [ngga_pkg::ZONE_W-1:0]       out_zone_two_hour,
  output logic [ngga_pkg::HOUR_W-1:0]       out_utc_minute,
  output logic [ngga_pkg::HOUR_W-1:0]       out_utc_second,
  output logic [ngga_pkg::DEG_W-1:0]        out_latitude_deg,
  output logic [ngga_pkg::DEG_W-1:0]        out_longitude_deg,
  output logic [ngga_pkg::SAT_W-1:0]        out_satellites,
  // configuration
  input  logic                              cfg_we,
  input  logic [ngga_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ngga_pkg::OFFSET_W-1:0]     cfg_wdata
);
  import ngga_pkg::*;

  localparam int FRAC_W = frac_width(FRAC_DIGITS);
  localparam int NST    = 6;

  // zone offsets
  logic [OFFSET_W-1:0] zone_one_r, zone_two_r;

  // parse state
  logic               at_start_r;
  logic               dollar_r, dollar_nxt;
  logic [3:0]         field_r, field_nxt;
  logic [3:0]         cif_r, cif_nxt;
  logic [3:0]         td_r [0:TIME_CHARS-1];
  logic [3:0]         td_nxt [0:TIME_CHARS-1];
  logic [IPART_W-1:0] lat_i_r, lat_i_nxt, lon_i_r, lon_i_nxt;
  logic [FRAC_W-1:0]  lat_f_r, lat_f_nxt, lon_f_r, lon_f_nxt;
  logic [2:0]         fcnt_r, fcnt_nxt;
  logic               point_r, point_nxt;
  logic               stop_r, stop_nxt;
  logic [SAT_W-1:0]   sat_r, sat_nxt;

  // pipeline control
  logic [NST:1]   v_r, v_nxt;
  logic [NST:1]   ld;
  logic [NST+1:1] free;
  logic           ld_out;
  logic           in_fire;

  // first stage: finished sentence
  logic               p1_ok_r;
  logic [3:0]         p1_td_r [0:TIME_CHARS-1];
  logic [IPART_W-1:0] p1_lat_i_r, p1_lon_i_r;
  logic [FRAC_W-1:0]  p1_lat_f_r, p1_lon_f_r;
  logic [SAT_W-1:0]   p1_sat_r;

  side_t side_r [2:NST];
  side_t side_nxt;

  conv_ld_t         conv_ld;
  logic [DEG_W-1:0] lat_deg, lon_deg, lat_sat, lon_sat;

  // output register, value fields double as the held results
  logic               out_valid_r;
  logic               out_ok_r;
  logic [HOUR_W-1:0]  out_hour_r, out_min_r, out_sec_r;
  logic [ZONE_W-1:0]  out_z1_r, out_z2_r;
  logic [DEG_W-1:0]   out_lat_r, out_lon_r;
  logic [SAT_W-1:0]   out_sat_r;

  logic       is_digit;
  logic [3:0] digit;

  assign in_fire  = in_valid && in_ready;
  assign is_digit = (in_char_byte >= CH_ZERO) && (in_char_byte <= CH_NINE);
  assign digit    = is_digit ? 4'(in_char_byte - CH_ZERO) : 4'd0;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_one_r <= ZONE_ONE_RST;
      zone_two_r <= ZONE_TWO_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ZONE_ONE: zone_one_r <= cfg_wdata;
        CFG_ZONE_TWO: zone_two_r <= cfg_wdata;
      endcase
    end
  end

  // per-character parse step
  always_comb begin
    logic [IPART_W-1:0] cur_i;
    logic [FRAC_W-1:0]  cur_f;
    logic [17:0]        ipart_mul;
    logic [2:0]         wt_idx;
    logic [10:0]        sat_mul;

    // sentence start clears the working state
    if (at_start_r) begin
      dollar_nxt = (in_char_byte == CH_DOLLAR);
      field_nxt  = '0;
      cif_nxt    = '0;
      for (int i = 0; i < TIME_CHARS; i++) td_nxt[i] = '0;
      lat_i_nxt  = '0;
      lat_f_nxt  = '0;
      lon_i_nxt  = '0;
      lon_f_nxt  = '0;
      fcnt_nxt   = '0;
      point_nxt  = 1'b0;
      stop_nxt   = 1'b0;
      sat_nxt    = '0;
    end else begin
      dollar_nxt = dollar_r;
      field_nxt  = field_r;
      cif_nxt    = cif_r;
      for (int i = 0; i < TIME_CHARS; i++) td_nxt[i] = td_r[i];
      lat_i_nxt  = lat_i_r;
      lat_f_nxt  = lat_f_r;
      lon_i_nxt  = lon_i_r;
      lon_f_nxt  = lon_f_r;
      fcnt_nxt   = fcnt_r;
      point_nxt  = point_r;
      stop_nxt   = stop_r;
      sat_nxt    = sat_r;
    end

    // active coordinate
    cur_i     = (field_nxt == FLD_LON) ? lon_i_nxt : lat_i_nxt;
    cur_f     = (field_nxt == FLD_LON) ? lon_f_nxt : lat_f_nxt;
    ipart_mul = 18'(cur_i) * 18'd10 + 18'(digit);
    wt_idx    = 3'(FRAC_DIGITS - 1) - fcnt_nxt;
    sat_mul   = 11'(sat_nxt) * 11'd10 + 11'(digit);

    if (in_char_byte == CH_COMMA) begin
      if (field_nxt != CNT_MAX) field_nxt = field_nxt + 4'd1;
      cif_nxt   = '0;
      fcnt_nxt  = '0;
      point_nxt = 1'b0;
      stop_nxt  = 1'b0;
    end else begin
      if (field_nxt == FLD_TIME && cif_nxt < 4'(TIME_CHARS)) begin
        td_nxt[cif_nxt[2:0]] = digit;
      end else if (cif_nxt < 4'(FIELD_CHARS)) begin
        if ((field_nxt == FLD_LAT || field_nxt == FLD_LON) && !stop_nxt) begin
          if (is_digit) begin
            if (!point_nxt) begin
              if (ipart_mul > 18'(IPART_MAX)) begin
                cur_i = IPART_MAX;
                cur_f = '0;
              end else begin
                cur_i = IPART_W'(ipart_mul);
              end
            end else if (fcnt_nxt < 3'(FRAC_DIGITS)) begin
              cur_f    = cur_f + FRAC_W'(POW10[wt_idx]) * FRAC_W'(digit);
              fcnt_nxt = fcnt_nxt + 3'd1;
              // at 180 degrees any fraction saturates away
              if (cur_i == IPART_MAX) cur_f = '0;
            end
          end else if (in_char_byte == CH_POINT && !point_nxt) begin
            point_nxt = 1'b1;
          end else begin
            stop_nxt = 1'b1;
          end
          if (field_nxt == FLD_LON) begin
            lon_i_nxt = cur_i;
            lon_f_nxt = cur_f;
          end else begin
            lat_i_nxt = cur_i;
            lat_f_nxt = cur_f;
          end
        end else if (field_nxt == FLD_SAT && !stop_nxt) begin
          if (is_digit) begin
            sat_nxt = (sat_mul > 11'(SAT_MAX)) ? SAT_MAX : SAT_W'(sat_mul);
          end else begin
            stop_nxt = 1'b1;
          end
        end
      end
      if (cif_nxt != CNT_MAX) cif_nxt = cif_nxt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      dollar_r   <= 1'b0;
      field_r    <= '0;
      cif_r      <= '0;
      for (int i = 0; i < TIME_CHARS; i++) td_r[i] <= '0;
      lat_i_r    <= '0;
      lat_f_r    <= '0;
      lon_i_r    <= '0;
      lon_f_r    <= '0;
      fcnt_r     <= '0;
      point_r    <= 1'b0;
      stop_r     <= 1'b0;
      sat_r      <= '0;
    end else if (in_fire) begin
      at_start_r <= in_last_char;
      dollar_r   <= dollar_nxt;
      field_r    <= field_nxt;
      cif_r      <= cif_nxt;
      for (int i = 0; i < TIME_CHARS; i++) td_r[i] <= td_nxt[i];
      lat_i_r    <= lat_i_nxt;
      lat_f_r    <= lat_f_nxt;
      lon_i_r    <= lon_i_nxt;
      lon_f_r    <= lon_f_nxt;
      fcnt_r     <= fcnt_nxt;
      point_r    <= point_nxt;
      stop_r     <= stop_nxt;
      sat_r      <= sat_nxt;
    end
  end

  // elastic pipeline: a stage takes a word when empty or when it moves on
  always_comb begin
    free[NST+1] = !out_valid_r || out_ready;
    for (int k = NST; k >= 1; k--) free[k] = !v_r[k] || free[k+1];
    ld[1] = in_valid && free[1] && in_last_char;
    for (int k = 2; k <= NST; k++) ld[k] = v_r[k-1] && free[k];
    for (int k = 1; k <= NST; k++) v_nxt[k] = ld[k] || (v_r[k] && !free[k+1]);
    ld_out = v_r[NST] && free[NST+1];
  end

  assign in_ready = free[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // capture the finished sentence
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      p1_ok_r    <= dollar_nxt;
      for (int i = 0; i < TIME_CHARS; i++) p1_td_r[i] <= td_nxt[i];
      p1_lat_i_r <= lat_i_nxt;
      p1_lat_f_r <= lat_f_nxt;
      p1_lon_i_r <= lon_i_nxt;
      p1_lon_f_r <= lon_f_nxt;
      p1_sat_r   <= sat_nxt;
    end
  end

  // time fields and zone hours
  always_comb begin
    side_nxt.ok       = p1_ok_r;
    side_nxt.hour     = two_digit(p1_td_r[0], p1_td_r[1]);
    side_nxt.zone_one = mod24(8'(side_nxt.hour) + 8'(zone_one_r));
    side_nxt.zone_two = mod24(8'(side_nxt.hour) + 8'(zone_two_r));
    side_nxt.minute   = two_digit(p1_td_r[2], p1_td_r[3]);
    side_nxt.second   = two_digit(p1_td_r[4], p1_td_r[5]);
    side_nxt.sat      = p1_sat_r;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) side_r[2] <= side_nxt;
    for (int k = 3; k <= NST; k++) begin
      if (ld[k]) side_r[k] <= side_r[k-1];
    end
  end

  // degree conversion, one unit per coordinate
  assign conv_ld = '{deg: ld[2], mins: ld[3], prod: ld[4], quot: ld[5], sum: ld[6]};

  ngga_coord_conv #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_lat_conv (
    .clk     (clk),
    .ld      (conv_ld),
    .ipart_i (p1_lat_i_r),
    .frac_i  (p1_lat_f_r),
    .deg_o   (lat_deg)
  );

  ngga_coord_conv #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_lon_conv (
    .clk     (clk),
    .ld      (conv_ld),
    .ipart_i (p1_lon_i_r),
    .frac_i  (p1_lon_f_r),
    .deg_o   (lon_deg)
  );

  assign lat_sat = (lat_deg > DEG_LIMIT) ? DEG_LIMIT : lat_deg;
  assign lon_sat = (lon_deg > DEG_LIMIT) ? DEG_LIMIT : lon_deg;

  // output register; a bad sentence repeats the held values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_ok_r    <= 1'b0;
      out_hour_r  <= '0;
      out_z1_r    <= '0;
      out_z2_r    <= '0;
      out_min_r   <= '0;
      out_sec_r   <= '0;
      out_lat_r   <= '0;
      out_lon_r   <= '0;
      out_sat_r   <= '0;
    end else begin
      out_valid_r <= ld_out || (out_valid_r && !out_ready);
      if (ld_out) begin
        out_ok_r <= side_r[NST].ok;
        if (side_r[NST].ok) begin
          out_hour_r <= side_r[NST].hour;
          out_z1_r   <= side_r[NST].zone_one;
          out_z2_r   <= side_r[NST].zone_two;
          out_min_r  <= side_r[NST].minute;
          out_sec_r  <= side_r[NST].second;
          out_lat_r  <= lat_sat;
          out_lon_r  <= lon_sat;
          out_sat_r  <= side_r[NST].sat;
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sentence_ok   = out_ok_r;
  assign out_utc_hour      = out_hour_r;
  assign out_zone_one_hour = out_z1_r;
  assign out_zone_two_hour = out_z2_r;
  assign out_utc_minute    = out_min_r;
  assign out_utc_second    = out_sec_r;
  assign out_latitude_deg  = out_lat_r;
  assign out_longitude_deg = out_lon_r;
  assign out_satellites    = out_sat_r;

`ifndef NO_ASSERTIONS
  // input stalls only when every stage and the output are full and blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");

  // the word after a last character starts a new sentence
  a_new_sentence: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_char |=> at_start_r)
    else $error("sentence start not armed after last character");

  // a bad sentence keeps the held values
  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out && !side_r[NST].ok |=> !out_sentence_ok && $stable(out_latitude_deg)
      && $stable(out_longitude_deg) && $stable(out_utc_hour) && $stable(out_satellites))
    else $error("held result changed on a bad sentence");

  // saturated latitude carries no fraction
  a_lat_sat: assert property (@(posedge clk) disable iff (!rst_n)
    lat_i_r == IPART_MAX |-> lat_f_r == '0)
    else $error("latitude above the saturation limit");

  // converted degrees stay in range
  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_latitude_deg <= DEG_LIMIT && out_longitude_deg <= DEG_LIMIT)
    else $error("degree result above limit");
`endif

endmodule

>>> hdl/ngga_coord_conv.sv
module ngga_coord_conv #(
  parameter int FRAC_DIGITS = ngga_pkg::FRAC_DIGITS_DEF
) (
  input  logic                                             clk,
  input  ngga_pkg::conv_ld_t                               ld,
  input  logic [ngga_pkg::IPART_W-1:0]                     ipart_i,
  input  logic [ngga_pkg::frac_width(FRAC_DIGITS)-1:0]     frac_i,
  output logic [ngga_pkg::DEG_W-1:0]                       deg_o
);
  import ngga_pkg::*;

  localparam int FRAC_W = frac_width(FRAC_DIGITS);

  // minutes scaled to 1e-7 units before the divide by 60
  localparam logic [29:0] FRAC_SCALE = 30'(pow10(7 - FRAC_DIGITS));

  // floor(i/100) = floor((i>>2)*20972 >> 19) for i up to 18000
  localparam logic [14:0] DEG_RECIP = 15'd20972;
  localparam int          DEG_SHIFT = 19;

  // floor(x/15) estimate, low by at most one
  localparam logic [28:0] Q15_RECIP = 29'h11111111;

  logic [7:0]         deg2_r, deg3_r;
  logic [IPART_W-1:0] ip2_r;
  logic [FRAC_W-1:0]  fr2_r, fr3_r;
  logic [6:0]         mm3_r;
  logic [29:0]        x4_r;
  logic [DEG_W-1:0]   dp4_r, dp5_r;
  logic [27:0]        xq5_r;
  logic [24:0]        qe5_r;
  logic [DEG_W-1:0]   r6_r;

  logic [27:0] deg_prod;
  logic [14:0] hund;
  logic [56:0] q_prod;
  logic [27:0] rem;
  logic [24:0] q_fix;

  // whole degrees
  assign deg_prod = 28'(ipart_i[IPART_W-1:2]) * 28'(DEG_RECIP);

  // minutes left over after whole degrees
  assign hund = 15'(deg2_r) * 15'd100;

  // reciprocal estimate of minutes / 60
  assign q_prod = 57'(x4_r[29:2]) * 57'(Q15_RECIP);

  // one-step quotient correction
  assign rem   = xq5_r - 28'(qe5_r) * 28'd15;
  assign q_fix = qe5_r + 25'(rem >= 28'd15);

  always_ff @(posedge clk) begin
    if (ld.deg) begin
      deg2_r <= 8'(deg_prod >> DEG_SHIFT);
      ip2_r  <= ipart_i;
      fr2_r  <= frac_i;
    end
    if (ld.mins) begin
      deg3_r <= deg2_r;
      mm3_r  <= 7'(ip2_r - hund);
      fr3_r  <= fr2_r;
    end
    if (ld.prod) begin
      x4_r  <= 30'(mm3_r) * 30'(DEG_UNIT) + 30'(fr3_r) * FRAC_SCALE;
      dp4_r <= DEG_W'(deg3_r) * DEG_W'(DEG_UNIT);
    end
    if (ld.quot) begin
      xq5_r <= x4_r[29:2];
      qe5_r <= q_prod[56:32];
      dp5_r <= dp4_r;
    end
    if (ld.sum) begin
      r6_r <= dp5_r + DEG_W'(q_fix);
    end
  end

  assign deg_o = r6_r;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ngga_pkg::*;

  localparam int                CLK_HALF    = 4;
  localparam int                CYCLE_LIMIT = 1000000;
  localparam int                RAND_CHARS  = 700;
  localparam longint unsigned   COORD_SCALE = 64'd10 ** FRAC_DIGITS_DEF;
  localparam longint unsigned   COORD_MAX   = 64'd18000 * COORD_SCALE;

  // one decoded position fix as the block reports it
  typedef struct packed {
    logic              ok;
    logic [HOUR_W-1:0] hour;
    logic [ZONE_W-1:0] zone_one;
    logic [ZONE_W-1:0] zone_two;
    logic [HOUR_W-1:0] minute;
    logic [HOUR_W-1:0] second;
    logic [DEG_W-1:0]  lat;
    logic [DEG_W-1:0]  lon;
    logic [SAT_W-1:0]  sat;
  } gga_fix_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_char_byte;
  logic                 in_last_char;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_sentence_ok;
  logic [HOUR_W-1:0]    out_utc_hour;
  logic [ZONE_W-1:0]    out_zone_one_hour;
  logic [ZONE_W-1:0]    out_zone_two_hour;
  logic [HOUR_W-1:0]    out_utc_minute;
  logic [HOUR_W-1:0]    out_utc_second;
  logic [DEG_W-1:0]     out_latitude_deg;
  logic [DEG_W-1:0]     out_longitude_deg;
  logic [SAT_W-1:0]     out_satellites;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [OFFSET_W-1:0]  cfg_wdata;

  nmea_gga_sentence_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_byte      (in_char_byte),
    .in_last_char      (in_last_char),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sentence_ok   (out_sentence_ok),
    .out_utc_hour      (out_utc_hour),
    .out_zone_one_hour (out_zone_one_hour),
    .out_zone_two_hour (out_zone_two_hour),
    .out_utc_minute    (out_utc_minute),
    .out_utc_second    (out_utc_second),
    .out_latitude_deg  (out_latitude_deg),
    .out_longitude_deg (out_longitude_deg),
    .out_satellites    (out_satellites),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // parser shadow state
  bit [OFFSET_W-1:0] zone_one_off;
  bit [OFFSET_W-1:0] zone_two_off;
  bit                p_start;
  bit                p_dollar;
  int unsigned       p_field;
  int unsigned       p_pos;
  bit [3:0]          p_time [TIME_CHARS];
  longint unsigned   p_coord [2];
  int unsigned       p_frac;
  bit                p_point;
  bit                p_stop;
  int unsigned       p_sats;
  gga_fix_t          p_held;

  gga_fix_t    expected_fixes [$];
  bit [7:0]    line_buf [$];
  bit          no_idle;
  int          fail_count;
  int          chars_taken;
  int          fixes_checked;
  int          offset_writes;
  int          cycle_count;

  // clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  function void clear_sentence();
    int i;
    p_dollar = 1'b0;
    p_field  = 0;
    p_pos    = 0;
    for (i = 0; i < TIME_CHARS; i++) p_time[i] = '0;
    p_coord[0] = 0;
    p_coord[1] = 0;
    p_frac  = 0;
    p_point = 1'b0;
    p_stop  = 1'b0;
    p_sats  = 0;
  endfunction

  function void reset_parser();
    zone_one_off = ZONE_ONE_RST;
    zone_two_off = ZONE_TWO_RST;
    clear_sentence();
    p_start = 1'b1;
    p_held  = '0;
  endfunction

  // ddmm.mmmm accumulation, fraction kept as a scaled integer
  function void coord_step(input int k, input bit [7:0] c, input bit is_digit, input int d);
    longint unsigned w;
    int unsigned i;
    if (p_stop) return;
    if (is_digit) begin
      if (!p_point) begin
        p_coord[k] = p_coord[k] * 10 + longint'(d) * COORD_SCALE;
      end else if (p_frac < FRAC_DIGITS_DEF) begin
        w = COORD_SCALE;
        for (i = 0; i <= p_frac; i++) w = w / 10;
        p_coord[k] = p_coord[k] + longint'(d) * w;
        p_frac++;
      end
      if (p_coord[k] > COORD_MAX) p_coord[k] = COORD_MAX;
    end else if (c == CH_POINT && !p_point) begin
      p_point = 1'b1;
    end else begin
      p_stop = 1'b1;
    end
  endfunction

  function bit [DEG_W-1:0] to_degrees(input longint unsigned acc);
    longint unsigned whole;
    longint unsigned mins;
    longint unsigned r;
    whole = acc / (100 * COORD_SCALE);
    mins  = acc % (100 * COORD_SCALE);
    r = whole * DEG_UNIT + (mins * DEG_UNIT) / (60 * COORD_SCALE);
    if (r > DEG_LIMIT) r = DEG_LIMIT;
    return r[DEG_W-1:0];
  endfunction

  // feed one character; returns 1 when a fix is produced
  function bit parse_char(input bit [7:0] c, input bit is_last, output gga_fix_t fix);
    bit is_digit;
    int d;
    int hour;
    is_digit = (c >= CH_ZERO && c <= CH_NINE);
    d = is_digit ? int'(c - CH_ZERO) : 0;
    fix = '0;
    if (p_start) begin
      clear_sentence();
      p_dollar = (c == CH_DOLLAR);
      p_start  = 1'b0;
    end
    if (c == CH_COMMA) begin
      if (p_field < CNT_MAX) p_field++;
      p_pos   = 0;
      p_frac  = 0;
      p_point = 1'b0;
      p_stop  = 1'b0;
    end else begin
      if (p_field == FLD_TIME && p_pos < TIME_CHARS) begin
        p_time[p_pos] = 4'(d);
      end else if (p_pos < FIELD_CHARS_DEF) begin
        if (p_field == FLD_LAT) begin
          coord_step(0, c, is_digit, d);
        end else if (p_field == FLD_LON) begin
          coord_step(1, c, is_digit, d);
        end else if (p_field == FLD_SAT && !p_stop) begin
          if (is_digit) begin
            p_sats = p_sats * 10 + d;
            if (p_sats > SAT_MAX) p_sats = SAT_MAX;
          end else begin
            p_stop = 1'b1;
          end
        end
      end
      if (p_pos < CNT_MAX) p_pos++;
    end
    if (!is_last) return 1'b0;
    p_start = 1'b1;
    if (p_dollar) begin
      hour = int'(p_time[0]) * 10 + int'(p_time[1]);
      p_held.hour     = HOUR_W'(hour);
      p_held.zone_one = ZONE_W'((hour + zone_one_off) % 24);
      p_held.zone_two = ZONE_W'((hour + zone_two_off) % 24);
      p_held.minute   = HOUR_W'(int'(p_time[2]) * 10 + int'(p_time[3]));
      p_held.second   = HOUR_W'(int'(p_time[4]) * 10 + int'(p_time[5]));
      p_held.lat      = to_degrees(p_coord[0]);
      p_held.lon      = to_degrees(p_coord[1]);
      p_held.sat      = SAT_W'(p_sats);
    end
    fix    = p_held;
    fix.ok = p_dollar;
    return 1'b1;
  endfunction

  task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // watch config writes, accepted characters and delivered fixes
  always @(posedge clk) begin : monitor
    gga_fix_t fix;
    gga_fix_t want;
    if (!rst_n) begin
      reset_parser();
      expected_fixes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ZONE_ONE: zone_one_off = cfg_wdata;
          CFG_ZONE_TWO: zone_two_off = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        chars_taken++;
        if (parse_char(in_char_byte, in_last_char, fix)) expected_fixes.push_back(fix);
      end
      if (out_valid && out_ready) begin
        fixes_checked++;
        if (expected_fixes.size() == 0) begin
          $display("%0t: unexpected fix word, expected none, actual hour %0d", $time,
                   out_utc_hour);
          fail_count++;
        end else begin
          want = expected_fixes.pop_front();
          check_field("sentence_ok", want.ok, out_sentence_ok);
          check_field("utc_hour", want.hour, out_utc_hour);
          check_field("zone_one_hour", want.zone_one, out_zone_one_hour);
          check_field("zone_two_hour", want.zone_two, out_zone_two_hour);
          check_field("utc_minute", want.minute, out_utc_minute);
          check_field("utc_second", want.second, out_utc_second);
          check_field("latitude_deg", want.lat, out_latitude_deg);
          check_field("longitude_deg", want.lon, out_longitude_deg);
          check_field("satellites", want.sat, out_satellites);
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d fixes still pending", $time, expected_fixes.size());
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task send_char(input bit [7:0] c, input bit is_last);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= c;
    in_last_char <= is_last;
    do @(posedge clk); while (!in_ready);
  endtask

  task send_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  task put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task put_digits(input int n);
    repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task send_sentence(input string s);
    line_buf.delete();
    put_text(s);
    send_line();
  endtask

  // drain the pipe before touching the offsets
  task wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task cfg_write(input cfg_idx_t idx, input bit [OFFSET_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    offset_writes++;
  endtask

  function bit [OFFSET_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return OFFSET_W'($urandom_range(0, 23));
    if (r < 80) return '0;
    if (r < 90) return OFFSET_W'(23);
    return OFFSET_W'($urandom_range(24, 31));
  endfunction

  // coordinate field, mostly well formed
  task put_coord(input int int_digits);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      put_digits(int_digits);
      put_text(".");
      put_digits(4);
    end else if (r < 78) begin
      put_digits($urandom_range(0, 10));
      if ($urandom_range(0, 1)) begin
        put_text(".");
        put_digits($urandom_range(0, 8));
      end
    end else if (r < 86) begin
      put_text(r[0] ? "17959.9999" : "18000.0001");
    end else if (r < 92) begin
      put_digits(int_digits);
      put_text(".");
      put_digits(2);
      put_text(".");
      put_digits(2);
    end else if (r < 97) begin
      put_digits(2);
      line_buf.push_back(8'($urandom_range(0, 255)));
      put_digits(3);
    end
  endtask

  // one random sentence, now and then broken or replaced by noise
  task build_gga();
    int r;
    int pos;
    line_buf.delete();
    put_text("$GPGGA,");
    r = $urandom_range(0, 99);
    if (r < 60) begin
      put_text($sformatf("%02d%02d%02d.%02d", $urandom_range(0, 23), $urandom_range(0, 59),
                         $urandom_range(0, 59), $urandom_range(0, 99)));
    end else if (r < 85) begin
      put_digits($urandom_range(0, 8));
    end else begin
      repeat (6) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    put_text(",");
    put_coord(4);
    put_text($urandom_range(0, 1) ? ",N," : ",S,");
    put_coord(5);
    put_text($urandom_range(0, 1) ? ",E," : ",W,");
    put_text($sformatf("%0d,", $urandom_range(0, 8)));
    r = $urandom_range(0, 99);
    if (r < 75) begin
      put_text($sformatf("%02d", $urandom_range(0, 24)));
    end else if (r < 90) begin
      put_text($sformatf("%0d", $urandom_range(0, 999)));
    end else begin
      put_digits(1);
      line_buf.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) put_text(",0.9,545.4,M,46.9,M,,*47");
    put_text("\r\n");

    r   = $urandom_range(0, 99);
    pos = $urandom_range(0, line_buf.size() - 1);
    if (r < 6) begin
      line_buf[0] = 8'($urandom_range(0, 255));
    end else if (r < 12) begin
      line_buf = line_buf[0:pos];
    end else if (r < 18) begin
      line_buf.insert(pos, 8'($urandom_range(0, 255)));
    end else if (r < 22) begin
      repeat ($urandom_range(1, 20)) line_buf.insert(pos, CH_COMMA);
    end else if (r < 28) begin
      line_buf.delete();
      repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else if (r < 31) begin
      line_buf.delete();
      line_buf.push_back(CH_DOLLAR);
    end
  endtask

  // reset offsets applied to a full and a short sentence
  task test_reset_offsets();
    send_sentence("$GPGGA,235959.00,4807.0380,N,01131.0000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    send_sentence("$GPGGA,061502.00,0000.0000,S,00000.0000,W,1,00");
  endtask

  // field extremes and parsing corner cases
  task test_corner_sentences();
    // lone start character
    send_sentence("$");
    // largest valid coordinates; minutes of 99 saturate the longitude
    send_sentence("$GPGGA,235959,17959.9999,N,17999.9999,E,1,99");
    // digit-less time character, dropped fifth fraction digit, sat overflow
    send_sentence("$,995a09,0000.00005,,9999999999,,,123");
    // not started with a dollar: held values come back
    send_sentence("G,120000,4530.1234,,00630.5,,,08");
    // short time, second point, junk in coordinate and sat fields
    send_sentence("$,1,12.3.4,,1x2,,,7y");
    // integer part clamps at 180 degrees, fraction only longitude
    send_sentence("$,000000,1800000,,.5,,,0");
    // overlong time field and more than fifteen commas
    send_sentence("$,12345678901234567890,,,,,,,,,,,,,,,,,,,,,5");
    // latitude longer than the counter range
    send_sentence("$,,12345678901234567,,,,,5");
    // all fields missing
    send_sentence("$GPGGA,,,,,,,,");
    // high and low byte values
    line_buf.delete();
    line_buf.push_back(8'hFF);
    put_text(",0,");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'h80);
    put_text("7");
    send_line();
  endtask

  // zone hour wrap across offset extremes
  task test_zone_offsets();
    bit [OFFSET_W-1:0] one_vals [5];
    bit [OFFSET_W-1:0] two_vals [5];
    int i;
    one_vals = '{5'd0, 5'd23, 5'd31, 5'd12, 5'd24};
    two_vals = '{5'd23, 5'd0, 5'd24, 5'd5, 5'd31};
    for (i = 0; i < 5; i++) begin
      wait_idle();
      cfg_write(CFG_ZONE_ONE, one_vals[i]);
      cfg_write(CFG_ZONE_TWO, two_vals[i]);
      send_sentence("$,230000");
      send_sentence("$,995959");
      send_sentence("$,000000");
    end
  endtask

  // random traffic with offset changes between batches
  task test_random_traffic();
    int first_chars;
    int batch;
    first_chars = chars_taken;
    batch = 0;
    while (chars_taken - first_chars < RAND_CHARS) begin
      if (batch % 8 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (batch % 12 == 11) begin
        wait_idle();
        cfg_write(CFG_ZONE_ONE, pick_offset());
        cfg_write(CFG_ZONE_TWO, pick_offset());
      end
      build_gga();
      send_line();
      batch++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_byte = '0;
    in_last_char = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ZONE_ONE;
    cfg_wdata    = '0;
    no_idle      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_offsets();
    test_corner_sentences();
    test_zone_offsets();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("summary: %0d characters sent, %0d fixes compared, %0d offset writes",
             chars_taken, fixes_checked, offset_writes);
    $display("summary: corner sentences, offset extremes and random broken traffic");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
